FILE: rtl/rrhc_pkg.sv
// shared types and constants for the rpc reply header checker
`default_nettype none
package rrhc_pkg;

	// result queue between parser and output stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// padded verifier length, up to 2^32 bytes
	localparam int SKIP_W = 33;

	localparam logic [31:0] MSG_REPLY      = 32'd1;
	localparam logic [31:0] REPLY_ACCEPTED = 32'd0;
	localparam logic [31:0] ACCEPT_SUCCESS = 32'd0;
	localparam logic [31:0] ACCEPT_MAX     = 32'd5;
	localparam logic [2:0]  AC_NONE        = 3'd0;
	localparam logic [2:0]  AC_OTHER       = 3'd6;

	typedef enum logic [2:0] {
		PH_XID    = 3'd0,
		PH_TYPE   = 3'd1,
		PH_RSTATE = 3'd2,
		PH_VFLAV  = 3'd3,
		PH_VLEN   = 3'd4,
		PH_VBODY  = 3'd5,
		PH_ASTATE = 3'd6,
		PH_BODY   = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TRUNCATED    = 3'd1,
		ST_XID_MISMATCH = 3'd2,
		ST_NOT_REPLY    = 3'd3,
		ST_REJECTED     = 3'd4,
		ST_TRUNC_HEADER = 3'd5,
		ST_CALL_FAILED  = 3'd6
	} status_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] payload_byte;
		logic       end_of_message;
		status_t    status;
		logic [2:0] accept_code;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/rrhc_front.sv
// front part: accepts bytes, tracks the header fields, builds result items
`default_nettype none
module rrhc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire logic             cfg_wr_en,
	input  wire logic [31:0]      cfg_wr_data,
	input  wire logic             q_full,
	output logic                  push,
	output rrhc_pkg::result_t     push_data
);

	logic [31:0]                 expected_xid_q;
	rrhc_pkg::phase_t            phase_q, phase_d;
	logic [31:0]                 word_q, word_d;
	logic [1:0]                  biw_q, biw_d;
	logic                        xm_q, xm_d;
	logic [rrhc_pkg::SKIP_W-1:0] skip_q, skip_d, skip_dec;
	rrhc_pkg::status_t           hs_q, hs_d;
	logic [2:0]                  ha_q, ha_d;
	logic [31:0]                 word;
	logic [1:0]                  biw_inc;
	logic                        accept;
	logic                        emit;
	rrhc_pkg::status_t           st;
	logic [2:0]                  ac;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign word     = {word_q[23:0], data_byte};
	assign biw_inc  = biw_q + 2'd1;
	assign skip_dec = skip_q - {{(rrhc_pkg::SKIP_W-1){1'b0}}, (skip_q != '0)};

	// next state
	always_comb begin
		phase_d = phase_q;
		word_d  = word_q;
		biw_d   = biw_q;
		xm_d    = xm_q;
		skip_d  = skip_q;
		hs_d    = hs_q;
		ha_d    = ha_q;
		if (accept) begin
			unique case (phase_q)
				rrhc_pkg::PH_BODY: begin
				end
				rrhc_pkg::PH_VBODY: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = rrhc_pkg::PH_ASTATE;
						biw_d   = 2'd0;
						word_d  = '0;
					end
				end
				default: begin
					word_d = word;
					biw_d  = biw_inc;
					if (biw_inc == 2'd0) begin
						word_d = '0;
						unique case (phase_q)
							rrhc_pkg::PH_XID: begin
								xm_d    = (word == expected_xid_q);
								phase_d = rrhc_pkg::PH_TYPE;
							end
							rrhc_pkg::PH_TYPE: begin
								if (!xm_q) begin
									hs_d    = rrhc_pkg::ST_XID_MISMATCH;
									phase_d = rrhc_pkg::PH_BODY;
								end else if (word != rrhc_pkg::MSG_REPLY) begin
									hs_d    = rrhc_pkg::ST_NOT_REPLY;
									phase_d = rrhc_pkg::PH_BODY;
								end else begin
									phase_d = rrhc_pkg::PH_RSTATE;
								end
							end
							rrhc_pkg::PH_RSTATE: begin
								if (word != rrhc_pkg::REPLY_ACCEPTED) begin
									hs_d    = rrhc_pkg::ST_REJECTED;
									phase_d = rrhc_pkg::PH_BODY;
								end else begin
									phase_d = rrhc_pkg::PH_VFLAV;
								end
							end
							rrhc_pkg::PH_VFLAV: begin
								phase_d = rrhc_pkg::PH_VLEN;
							end
							rrhc_pkg::PH_VLEN: begin
								skip_d = ({1'b0, word} + 33'd3) & ~33'd3;
								phase_d = ((({1'b0, word} + 33'd3) & ~33'd3) == '0) ?
									rrhc_pkg::PH_ASTATE : rrhc_pkg::PH_VBODY;
							end
							rrhc_pkg::PH_ASTATE: begin
								if (word != rrhc_pkg::ACCEPT_SUCCESS) begin
									hs_d = rrhc_pkg::ST_CALL_FAILED;
									ha_d = (word <= rrhc_pkg::ACCEPT_MAX) ? word[2:0]
										: rrhc_pkg::AC_OTHER;
								end
								phase_d = rrhc_pkg::PH_BODY;
							end
							default: begin
							end
						endcase
					end
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		emit = (phase_q == rrhc_pkg::PH_BODY) && (hs_q == rrhc_pkg::ST_OK);
		st   = rrhc_pkg::ST_OK;
		ac   = rrhc_pkg::AC_NONE;
		if (last_byte) begin
			if (hs_d != rrhc_pkg::ST_OK) begin
				st = hs_d;
				ac = ha_d;
			end else if (phase_d == rrhc_pkg::PH_XID || phase_d == rrhc_pkg::PH_TYPE) begin
				st = rrhc_pkg::ST_TRUNCATED;
			end else if (phase_d != rrhc_pkg::PH_BODY) begin
				st = rrhc_pkg::ST_TRUNC_HEADER;
			end
		end
		push                     = accept && (emit || last_byte);
		push_data.has_byte       = emit;
		push_data.payload_byte   = emit ? data_byte : 8'd0;
		push_data.end_of_message = last_byte;
		push_data.status         = st;
		push_data.accept_code    = ac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_xid_q <= '0;
		end else if (cfg_wr_en) begin
			expected_xid_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rrhc_pkg::PH_XID;
			word_q  <= '0;
			biw_q   <= '0;
			xm_q    <= 1'b0;
			skip_q  <= '0;
			hs_q    <= rrhc_pkg::ST_OK;
			ha_q    <= rrhc_pkg::AC_NONE;
		end else if (accept && last_byte) begin
			phase_q <= rrhc_pkg::PH_XID;
			word_q  <= '0;
			biw_q   <= '0;
			xm_q    <= 1'b0;
			skip_q  <= '0;
			hs_q    <= rrhc_pkg::ST_OK;
			ha_q    <= rrhc_pkg::AC_NONE;
		end else begin
			phase_q <= phase_d;
			word_q  <= word_d;
			biw_q   <= biw_d;
			xm_q    <= xm_d;
			skip_q  <= skip_d;
			hs_q    <= hs_d;
			ha_q    <= ha_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rrhc_queue.sv
// short result queue between parser and output stage
`default_nettype none
module rrhc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  rrhc_pkg::result_t  push_data,
	output logic               full,
	output logic               q_valid,
	output rrhc_pkg::result_t  q_data,
	input  wire logic          pop
);

	rrhc_pkg::result_t           entry_q [rrhc_pkg::QDEPTH];
	logic [rrhc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rrhc_pkg::QCNT_W-1:0] count_q;
	logic                        do_push, do_pop;

	localparam logic [rrhc_pkg::QCNT_W-1:0] DEPTH_CNT = rrhc_pkg::QCNT_W'(rrhc_pkg::QDEPTH);
	localparam logic [rrhc_pkg::QPTR_W-1:0] LAST_PTR  = rrhc_pkg::QPTR_W'(rrhc_pkg::QDEPTH - 1);

	assign full    = (count_q == DEPTH_CNT);
	assign q_valid = (count_q != '0);
	assign q_data  = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("queue count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue push lost");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue pop lost");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointer gap");

endmodule
`default_nettype wire

FILE: rtl/rrhc_back.sv
// back part: output register that drains the result queue
`default_nettype none
module rrhc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  rrhc_pkg::result_t  q_data,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rrhc_pkg::result_t  out_data
);

	logic              valid_q;
	rrhc_pkg::result_t data_q;

	assign pop       = q_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rpc_reply_header_checker.sv
// top level of the rpc reply header checker
//
// input channel: one reply message byte per transfer (data_byte), last_byte
// marks the final byte; in_valid/in_ready handshake
// output channel: at most one result per input byte, given for a payload
// byte or for the final byte; out_valid/out_ready handshake
// config: cfg_wr_en writes expected_xid from cfg_wr_data at once; the user must
// do so while no message is in flight, which the block itself does not enforce
// throughput: one byte per cycle while the result queue is not full, set by
// the front parser which handles each accepted byte as it arrives; a result
// is registered into the result queue, then into the output register
// a stalled receiver fills the four-entry result queue; in_ready falls only
// when the queue is full, and resumes as soon as one entry drains
// reset: parser back to the transaction id word, queue empty, out_valid low,
// expected_xid cleared to zero
`default_nettype none
module rpc_reply_header_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             has_byte,
	output logic [7:0]       payload_byte,
	output logic             end_of_message,
	output logic [2:0]       status,
	output logic [2:0]       accept_code
);

	// parser to queue
	logic              q_full;
	logic              push;
	rrhc_pkg::result_t push_data;

	// queue to output stage
	logic              q_valid;
	logic              pop;
	rrhc_pkg::result_t q_data;
	rrhc_pkg::result_t out_data;

	// header parsing and result building, one byte per transfer
	rrhc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	// decouples the parser from receiver stalls
	rrhc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop)
	);

	// registered output stage
	rrhc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// result fields onto their own ports
	assign has_byte       = out_data.has_byte;
	assign payload_byte   = out_data.payload_byte;
	assign end_of_message = out_data.end_of_message;
	assign status         = out_data.status;
	assign accept_code    = out_data.accept_code;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the rpc reply header checker
module testbench;
	import rrhc_pkg::*;

	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_BYTES  = 1320;
	localparam int SETTLE_CYCLES = 4;      // margin past the result queue and output register
	localparam int CYCLE_LIMIT   = 500000; // far above the slowest legal run

	// one directed reply: register value, header words, payload size and cut point
	typedef struct packed {
		logic [31:0] xid_cfg;
		logic [31:0] w_xid;
		logic [31:0] w_type;
		logic [31:0] w_rst;
		logic [31:0] w_flav;
		logic [31:0] w_vlen;
		logic [31:0] w_ast;
		logic [7:0]  paylen;
		logic [7:0]  cut;      // 0 sends the whole reply
		logic        typed;    // final status written in the row
		status_t     st;
		logic [2:0]  ac;
	} reply_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        out_valid;
	logic        out_ready;
	logic        has_byte;
	logic [7:0]  payload_byte;
	logic        end_of_message;
	logic [2:0]  status;
	logic [2:0]  accept_code;

	// header parser mirror, one copy of the block's message state
	phase_t      parse_phase;
	logic [31:0] word_acc;
	logic [1:0]  byte_pos;
	logic        xid_ok;
	logic [33:0] skip_left;
	status_t     held_st;
	logic [2:0]  held_ac;
	logic [31:0] xid_setting;

	// results still owed by the block, oldest first
	result_t     awaited[$];

	int          fail_count;
	int          bytes_sent;
	int          cycle_count;
	int          ready_hold;
	bit          steady_run;

	rpc_reply_header_checker u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.has_byte       (has_byte),
		.payload_byte   (payload_byte),
		.end_of_message (end_of_message),
		.status         (status),
		.accept_code    (accept_code)
	);

	always #2 clk = ~clk;

	// run guard: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver back-pressure: short stalls, a few long ones, and free-running stretches
	always @(posedge clk) begin : ready_gen
		int pick;
		pick = $urandom_range(0, 99);
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (pick < 10) begin
			out_ready  <= 1'b1;
			ready_hold <= $urandom_range(20, 80);
		end else if (pick < 60) begin
			out_ready  <= 1'b1;
			ready_hold <= $urandom_range(0, 3);
		end else if (pick < 95) begin
			out_ready  <= 1'b0;
			ready_hold <= $urandom_range(0, 3);
		end else begin
			out_ready  <= 1'b0;
			ready_hold <= $urandom_range(8, 24);
		end
	end

	// back to the start of a message, register untouched
	task automatic clear_parse();
		parse_phase = PH_XID;
		word_acc    = '0;
		byte_pos    = '0;
		xid_ok      = 1'b0;
		skip_left   = '0;
		held_st     = ST_OK;
		held_ac     = AC_NONE;
	endtask

	// advance the mirror by one accepted byte and queue any result it owes
	task automatic parse_reply_byte(input logic [7:0] b, input logic lst);
		logic        emit;
		logic [31:0] w;
		logic [33:0] padded;
		result_t     r;
		emit = 1'b0;
		case (parse_phase)
			PH_BODY: begin
				// payload passes only while no error is held
				emit = (held_st == ST_OK);
			end
			PH_VBODY: begin
				if (skip_left != '0)
					skip_left = skip_left - 34'd1;
				if (skip_left == '0) begin
					parse_phase = PH_ASTATE;
					byte_pos    = '0;
					word_acc    = '0;
				end
			end
			default: begin
				// big-endian word assembly
				word_acc = {word_acc[23:0], b};
				byte_pos = byte_pos + 2'd1;
				if (byte_pos == 2'd0) begin
					w        = word_acc;
					word_acc = '0;
					case (parse_phase)
						PH_XID: begin
							xid_ok      = (w == xid_setting);
							parse_phase = PH_TYPE;
						end
						PH_TYPE: begin
							// xid mismatch wins over a wrong message type
							if (!xid_ok) begin
								held_st     = ST_XID_MISMATCH;
								parse_phase = PH_BODY;
							end else if (w != MSG_REPLY) begin
								held_st     = ST_NOT_REPLY;
								parse_phase = PH_BODY;
							end else begin
								parse_phase = PH_RSTATE;
							end
						end
						PH_RSTATE: begin
							if (w != REPLY_ACCEPTED) begin
								held_st     = ST_REJECTED;
								parse_phase = PH_BODY;
							end else begin
								parse_phase = PH_VFLAV;
							end
						end
						PH_VFLAV: parse_phase = PH_VLEN;
						PH_VLEN: begin
							// padded length kept at full width, up to 2^32
							padded      = ({2'b00, w} + 34'd3) & ~34'd3;
							skip_left   = padded;
							parse_phase = (padded == '0) ? PH_ASTATE : PH_VBODY;
						end
						PH_ASTATE: begin
							if (w != ACCEPT_SUCCESS) begin
								held_st = ST_CALL_FAILED;
								held_ac = (w <= ACCEPT_MAX) ? w[2:0] : AC_OTHER;
							end
							parse_phase = PH_BODY;
						end
						default: ;
					endcase
				end
			end
		endcase

		if (emit || lst) begin
			r.has_byte       = emit;
			r.payload_byte   = emit ? b : 8'h00;
			r.end_of_message = lst;
			r.status         = ST_OK;
			r.accept_code    = AC_NONE;
			if (lst) begin
				if (held_st != ST_OK) begin
					r.status      = held_st;
					r.accept_code = held_ac;
				end else if (parse_phase == PH_XID || parse_phase == PH_TYPE) begin
					r.status = ST_TRUNCATED;
				end else if (parse_phase != PH_BODY) begin
					r.status = ST_TRUNC_HEADER;
				end
				clear_parse();
			end
			awaited.push_back(r);
		end
	endtask

	// sender gap before the next transfer
	function automatic int pick_gap(input bit steady);
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 50)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 2);
		if (pick < 98)
			return $urandom_range(3, 6);
		return $urandom_range(10, 20);
	endfunction

	// one input transfer; called at a rising edge, returns at the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = pick_gap(steady_run);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		parse_reply_byte(b, lst);
		bytes_sent++;
	endtask

	// stop sending and wait out every owed result plus the pipeline depth
	task automatic drain_block();
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_xid(input logic [31:0] v);
		drain_block();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		xid_setting = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// build a reply from header words and stream it, cut short when asked
	task automatic send_reply(input logic [31:0] w_xid, w_type, w_rst, w_flav, w_vlen,
		w_ast, input int paylen, input int cut);
		logic [31:0] hdr [5];
		longint      padded;
		longint      total;
		longint      len;
		longint      i;
		logic [7:0]  b;
		hdr[0] = w_xid;
		hdr[1] = w_type;
		hdr[2] = w_rst;
		hdr[3] = w_flav;
		hdr[4] = w_vlen;
		padded = (longint'(w_vlen) + 3) & ~longint'(3);
		total  = 24 + padded + paylen;
		len    = (cut > 0 && cut < total) ? cut : total;
		steady_run = ($urandom_range(0, 7) == 0);
		for (i = 0; i < len; i++) begin
			if (i < 20)
				b = 8'(hdr[i / 4] >> (8 * (3 - (i % 4))));
			else if (i < 20 + padded)
				b = 8'($urandom);
			else if (i < 24 + padded)
				b = 8'(w_ast >> (8 * (3 - (i - 20 - padded))));
			else
				b = 8'($urandom);
			send_byte(b, i == len - 1);
		end
	endtask

	// mostly well-formed replies with random content, some broken or noise
	task automatic random_reply();
		logic [31:0] w_xid, w_type, w_rst, w_flav, w_vlen, w_ast;
		int          paylen;
		int          cut;
		int          kind;
		w_xid  = xid_setting;
		w_type = MSG_REPLY;
		w_rst  = REPLY_ACCEPTED;
		w_flav = $urandom;
		w_vlen = $urandom_range(0, 12);
		w_ast  = ACCEPT_SUCCESS;
		paylen = $urandom_range(0, 24);
		cut    = 0;
		kind   = $urandom_range(0, 99);
		if (kind < 8) begin
			// noise: random words, random verifier length, a cut point of at most 40 bytes
			w_xid  = $urandom;
			w_type = $urandom_range(0, 2);
			w_rst  = $urandom_range(0, 1);
			w_vlen = $urandom;
			w_ast  = $urandom_range(0, 7);
			cut    = $urandom_range(1, 40);
		end else if (kind < 12) begin
			w_xid = $urandom;
		end else if (kind < 16) begin
			w_type = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
		end else if (kind < 20) begin
			w_rst = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
		end else if (kind < 30) begin
			w_ast = $urandom_range(0, 1) ? $urandom_range(1, 7) : $urandom;
		end else if (kind < 35) begin
			w_vlen = $urandom;
			cut    = $urandom_range(1, 60);
		end else if (kind < 50) begin
			cut = $urandom_range(1, 27 + w_vlen + paylen);
		end else if (kind < 58) begin
			w_vlen = $urandom_range(13, 64);
			paylen = $urandom_range(25, 80);
		end
		send_reply(w_xid, w_type, w_rst, w_flav, w_vlen, w_ast, paylen, cut);
	endtask

	function automatic reply_row_t mk_row(input logic [31:0] xid_cfg, w_xid, w_type, w_rst,
		w_flav, w_vlen, w_ast, input int paylen, input int cut, input bit typed,
		input status_t st, input logic [2:0] ac);
		reply_row_t r;
		r.xid_cfg = xid_cfg;
		r.w_xid   = w_xid;
		r.w_type  = w_type;
		r.w_rst   = w_rst;
		r.w_flav  = w_flav;
		r.w_vlen  = w_vlen;
		r.w_ast   = w_ast;
		r.paylen  = 8'(paylen);
		r.cut     = 8'(cut);
		r.typed   = typed;
		r.st      = st;
		r.ac      = ac;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch on %s: expected %0h actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	// output transfers, compared with the oldest owed result
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				$display("%0t unexpected result: has_byte %0d payload %0h end %0d status %0d ac %0d",
					$time, has_byte, payload_byte, end_of_message, status, accept_code);
				fail_count++;
			end else begin
				want = awaited.pop_front();
				check_field("has_byte", 32'(want.has_byte), 32'(has_byte));
				check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
				check_field("end_of_message", 32'(want.end_of_message),
					32'(end_of_message));
				check_field("status", 32'(want.status), 32'(status));
				check_field("accept_code", 32'(want.accept_code), 32'(accept_code));
			end
		end
	end

	initial begin : stimulus
		localparam logic [31:0] XA = 32'h1234_5678;
		localparam logic [31:0] XO = 32'hFFFF_FFFF;
		reply_row_t dir_rows [21];
		int         k;
		int         rnd_start;

		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		data_byte   = 8'h00;
		last_byte   = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 32'h0;
		out_ready   = 1'b0;
		ready_hold  = 0;
		fail_count  = 0;
		bytes_sent  = 0;
		cycle_count = 0;
		steady_run  = 1'b0;
		xid_setting = 32'h0;
		clear_parse();

		//                  cfg  xid     type       rst  flav vlen          ast
		//                  pay cut typed status          accept
		// empty payload, every word but the type at zero
		dir_rows[0]  = mk_row(0,  0,      MSG_REPLY, 0,  0,  0,            0,
			0, 0,  1, ST_OK,           AC_NONE);
		// all-ones xid and flavour, payload bytes
		dir_rows[1]  = mk_row(XO, XO,     MSG_REPLY, 0,  XO, 3,            0,
			4, 0,  0, ST_OK,           AC_NONE);
		// single-byte message
		dir_rows[2]  = mk_row(XA, XA,     MSG_REPLY, 0,  0,  0,            0,
			0, 1,  1, ST_TRUNCATED,    AC_NONE);
		// ends inside the type word, xid already wrong: still truncated
		dir_rows[3]  = mk_row(XA, XA ^ 1, MSG_REPLY, 0,  0,  0,            0,
			0, 7,  1, ST_TRUNCATED,    AC_NONE);
		// xid and type both wrong: xid reported
		dir_rows[4]  = mk_row(XA, XA ^ 1, 2,         0,  0,  0,            0,
			3, 0,  1, ST_XID_MISMATCH, AC_NONE);
		dir_rows[5]  = mk_row(XA, XA,     0,         0,  0,  0,            0,
			2, 0,  1, ST_NOT_REPLY,    AC_NONE);
		dir_rows[6]  = mk_row(XA, XA,     XO,        0,  0,  0,            0,
			0, 0,  1, ST_NOT_REPLY,    AC_NONE);
		dir_rows[7]  = mk_row(XA, XA,     MSG_REPLY, 1,  0,  0,            0,
			0, 0,  1, ST_REJECTED,     AC_NONE);
		dir_rows[8]  = mk_row(XA, XA,     MSG_REPLY, XO, 0,  0,            0,
			2, 0,  1, ST_REJECTED,     AC_NONE);
		// ends inside the reply state word
		dir_rows[9]  = mk_row(XA, XA,     MSG_REPLY, 0,  0,  0,            0,
			0, 10, 1, ST_TRUNC_HEADER, AC_NONE);
		// ends inside the verifier body
		dir_rows[10] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  5,            0,
			0, 23, 1, ST_TRUNC_HEADER, AC_NONE);
		// padded length of exactly 2^32 must not wrap to zero
		dir_rows[11] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  32'hFFFF_FFFD, 0,
			0, 28, 1, ST_TRUNC_HEADER, AC_NONE);
		dir_rows[12] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  XO,           0,
			0, 21, 1, ST_TRUNC_HEADER, AC_NONE);
		dir_rows[13] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  0,            1,
			2, 0,  1, ST_CALL_FAILED,  3'd1);
		dir_rows[14] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  0,            5,
			0, 0,  1, ST_CALL_FAILED,  3'd5);
		dir_rows[15] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  0,            6,
			0, 0,  1, ST_CALL_FAILED,  AC_OTHER);
		dir_rows[16] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  0,            XO,
			1, 0,  1, ST_CALL_FAILED,  AC_OTHER);
		// ends inside the accept state word
		dir_rows[17] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  4,            0,
			0, 26, 1, ST_TRUNC_HEADER, AC_NONE);
		// ends right after the length word
		dir_rows[18] = mk_row(XA, XA,     MSG_REPLY, 0,  0,  0,            0,
			0, 20, 1, ST_TRUNC_HEADER, AC_NONE);
		dir_rows[19] = mk_row(0,  0,      MSG_REPLY, 0,  0,  1,            0,
			5, 0,  0, ST_OK,           AC_NONE);
		dir_rows[20] = mk_row(XO, XO,     MSG_REPLY, 0,  XO, 0,            0,
			1, 0,  0, ST_OK,           AC_NONE);

		// single reset pulse, released on a clock edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed replies, register rewritten before each one
		for (k = 0; k < 21; k++) begin
			write_xid(dir_rows[k].xid_cfg);
			send_reply(dir_rows[k].w_xid, dir_rows[k].w_type, dir_rows[k].w_rst,
				dir_rows[k].w_flav, dir_rows[k].w_vlen, dir_rows[k].w_ast,
				dir_rows[k].paylen, dir_rows[k].cut);
			// typed rows: final status from the row, not the mirror
			if (dir_rows[k].typed) begin
				awaited[awaited.size() - 1].status      = dir_rows[k].st;
				awaited[awaited.size() - 1].accept_code = dir_rows[k].ac;
			end
		end

		// random replies, occasionally draining to retune the expected xid
		rnd_start = bytes_sent;
		while (bytes_sent - rnd_start < RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 20) begin
				case ($urandom_range(0, 4))
					0:       write_xid(32'h0);
					1:       write_xid(32'hFFFF_FFFF);
					default: write_xid($urandom);
				endcase
			end
			random_reply();
		end

		// final drain with a settle margin for stray results
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: rpc_reply_header_checker.f
rtl/rrhc_pkg.sv
rtl/rrhc_front.sv
rtl/rrhc_queue.sv
rtl/rrhc_back.sv
rtl/rpc_reply_header_checker.sv
tb/sv/testbench.sv
